// ----- rtl/choppiness_index_of_true_range_defines.svh -----
`ifndef CHOPPINESS_INDEX_OF_TRUE_RANGE_DEFINES_SVH
`define CHOPPINESS_INDEX_OF_TRUE_RANGE_DEFINES_SVH

// same-cycle implication
`define CHOP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define CHOP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- rtl/chop_pkg.sv -----
package chop_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;
    localparam int PORT_PRICE_W   = 32;
    localparam int PERIOD_W       = 7;
    localparam int PERIOD_RESET   = 14;
    localparam int PERIOD_MIN     = 2;
    localparam int FRAC_BITS      = 16;
    localparam int MANT_BITS      = 32;
    localparam int SCALE_Q8       = 25600;
    localparam int SCALE_W        = 15;
    localparam int OUT_W          = 24;
    localparam int OUT_MIN_MAG    = 8388608;

    typedef enum logic [1:0] {
        LOG_SPREAD = 2'd0,
        LOG_SUM    = 2'd1,
        LOG_LEN    = 2'd2
    } t_log_sel;

    typedef struct packed {
        logic     cfg_write;
        logic     capture;
        logic     calc_tr;
        logic     load;
        logic     scan_start;
        logic     log_start;
        t_log_sel log_sel;
        logic     mul;
        logic     div_start;
        logic     set_undef;
        logic     set_zero;
        logic     set_div;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_pend;
        logic scan_done;
        logic emit;
        logic undef;
        logic log_done;
        logic spread_ge_sum;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/chop_log.sv -----
module chop_log #(
    parameter int XW = 38
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic [XW-1:0]                                 i_x,
    output logic                                          o_done,
    output logic [$clog2(XW)+chop_pkg::FRAC_BITS-1:0]     o_result
);

    localparam int EW = $clog2(XW);
    localparam int MW = chop_pkg::MANT_BITS;
    localparam int FB = chop_pkg::FRAC_BITS;
    localparam int KW = $clog2(FB);

    logic          r_norm;
    logic          r_frac;
    logic          r_done;
    logic [XW-1:0] r_x;
    logic [EW-1:0] r_e;
    logic [MW-1:0] r_m;
    logic [FB-1:0] r_fb;
    logic [KW-1:0] r_k;
    logic [2*MW-1:0] w_sq;
    logic [MW:0]     w_t;

    assign w_sq = r_m * r_m;
    assign w_t  = w_sq[2*MW-1:MW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm <= 1'b0;
            r_frac <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_norm <= 1'b1;
            end else if (r_norm && r_x[XW-1]) begin
                r_norm <= 1'b0;
                r_frac <= 1'b1;
            end else if (r_frac && r_k == '0) begin
                r_frac <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_e <= EW'(XW - 1);
        end else if (r_norm) begin
            if (r_x[XW-1]) begin
                r_m  <= r_x[XW-1 -: MW];
                r_k  <= KW'(FB - 1);
                r_fb <= '0;
            end else begin
                r_x <= r_x << 1;
                r_e <= r_e - EW'(1);
            end
        end else if (r_frac) begin
            r_fb <= {r_fb[FB-2:0], w_t[MW]};
            r_m  <= w_t[MW] ? w_t[MW:1] : w_t[MW-1:0];
            r_k  <= r_k - KW'(1);
        end
    end

    assign o_done   = r_done;
    assign o_result = {r_e, r_fb};

endmodule

// ----- rtl/chop_dp.sv -----
`include "choppiness_index_of_true_range_defines.svh"

module chop_dp #(
    parameter int WINDOW_MAX = chop_pkg::WINDOW_MAX_DEF,
    parameter int PRICE_BITS = chop_pkg::PRICE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  chop_pkg::t_cmd                         i_cmd,
    output chop_pkg::t_status                      o_status,
    input  logic [chop_pkg::PORT_PRICE_W-1:0]      i_high_price,
    input  logic [chop_pkg::PORT_PRICE_W-1:0]      i_low_price,
    input  logic [chop_pkg::PORT_PRICE_W-1:0]      i_close_price,
    input  logic [chop_pkg::PERIOD_W-1:0]          i_cfg_period_len,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [chop_pkg::OUT_W-1:0]      o_index_value,
    output logic                                   o_ratio_undefined
);

    localparam int P     = PRICE_BITS;
    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int NW    = $clog2(WINDOW_MAX + 1);
    localparam int SW    = P + AW;
    localparam int XW    = (SW > chop_pkg::MANT_BITS) ? SW : chop_pkg::MANT_BITS;
    localparam int LW    = $clog2(XW) + chop_pkg::FRAC_BITS;
    localparam int PW    = LW + chop_pkg::SCALE_W;
    localparam int DW    = PW + 1;
    localparam int CW    = $clog2(DW + 1);
    localparam int OW    = chop_pkg::OUT_W;
    localparam int N_RST = (chop_pkg::PERIOD_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                                   : chop_pkg::PERIOD_RESET;

    logic [P-1:0] mem [WINDOW_MAX];

    logic [NW-1:0] r_n;
    logic [P-1:0]  r_hi, r_lo, r_cl, r_prev, r_tr, r_rd_data;
    logic [SW-1:0] r_sum;
    logic [P-1:0]  r_max, r_min;
    logic [NW-1:0] r_max_age, r_min_age, r_bar;
    logic [AW-1:0] r_wpos, r_newest;
    logic          r_scan_max, r_scan_min, r_scan_done;

    logic          r_issue, r_rd_v, r_rd_last;
    logic [AW-1:0] r_scan_idx;
    logic [NW-1:0] r_scan_age, r_rd_age;
    logic [P-1:0]  r_bmax, r_bmin;
    logic [NW-1:0] r_bmax_age, r_bmin_age;

    chop_pkg::t_log_sel r_log_sel;
    logic [LW-1:0] r_ld, r_ls, r_ln;
    logic [PW-1:0] r_prod;
    logic [DW-1:0] r_dvd;
    logic [LW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_div_run, r_div_done;

    logic signed [OW-1:0] r_res, r_out_index;
    logic                 r_undef, r_out_undef, r_out_valid;

    logic [63:0]   w_hi_ext, w_lo_ext, w_cl_ext;
    logic [P-1:0]  w_hi2, w_lo2, w_old;
    logic [NW-1:0] w_max_age_inc, w_min_age_inc, w_n_cfg;
    logic [AW-1:0] w_newest_prev, w_scan_prev;
    logic [P-1:0]  w_bmax_nx, w_bmin_nx;
    logic [NW-1:0] w_bmax_age_nx, w_bmin_age_nx;
    logic          w_proc_last;
    logic [XW-1:0] w_log_x;
    logic          w_log_done;
    logic [LW-1:0] w_log_res;
    logic [LW-1:0] w_diff;
    logic [LW:0]   w_trial;
    logic          w_qbit;
    logic [OW-1:0] w_mag;

    assign w_hi_ext = {32'd0, i_high_price};
    assign w_lo_ext = {32'd0, i_low_price};
    assign w_cl_ext = {32'd0, i_close_price};

    always_comb begin
        if (int'(i_cfg_period_len) < chop_pkg::PERIOD_MIN) begin
            w_n_cfg = NW'(chop_pkg::PERIOD_MIN);
        end else if (int'(i_cfg_period_len) > WINDOW_MAX) begin
            w_n_cfg = NW'(WINDOW_MAX);
        end else begin
            w_n_cfg = NW'(i_cfg_period_len);
        end
    end

    // true range with previous close
    always_comb begin
        w_hi2 = r_hi;
        w_lo2 = r_lo;
        if (r_bar != '0) begin
            if (r_prev > r_hi) w_hi2 = r_prev;
            if (r_prev < r_lo) w_lo2 = r_prev;
        end
    end

    assign w_old         = (r_bar >= r_n) ? r_rd_data : '0;
    assign w_max_age_inc = r_max_age + NW'(1);
    assign w_min_age_inc = r_min_age + NW'(1);
    assign w_newest_prev = (r_newest == '0) ? AW'(r_n - NW'(1)) : r_newest - AW'(1);
    assign w_scan_prev   = (r_scan_idx == '0) ? AW'(r_n - NW'(1)) : r_scan_idx - AW'(1);

    // rescan compare, newest wins ties
    assign w_bmax_nx     = (r_rd_data > r_bmax) ? r_rd_data : r_bmax;
    assign w_bmax_age_nx = (r_rd_data > r_bmax) ? r_rd_age : r_bmax_age;
    assign w_bmin_nx     = (r_rd_data < r_bmin) ? r_rd_data : r_bmin;
    assign w_bmin_age_nx = (r_rd_data < r_bmin) ? r_rd_age : r_bmin_age;
    assign w_proc_last   = r_rd_v && r_rd_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) mem[r_wpos] <= r_tr;
        if (i_cmd.capture) begin
            r_rd_data <= mem[r_wpos];
        end else if (r_issue) begin
            r_rd_data <= mem[r_scan_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hi <= w_hi_ext[P-1:0];
            r_lo <= w_lo_ext[P-1:0];
            r_cl <= w_cl_ext[P-1:0];
        end
        if (i_cmd.calc_tr) begin
            r_tr <= (w_hi2 > w_lo2) ? w_hi2 - w_lo2 : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= NW'(N_RST);
            r_sum       <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_max_age   <= '0;
            r_min_age   <= '0;
            r_prev      <= '0;
            r_bar       <= '0;
            r_wpos      <= '0;
            r_newest    <= '0;
            r_scan_max  <= 1'b0;
            r_scan_min  <= 1'b0;
            r_scan_done <= 1'b0;
        end else if (i_cmd.cfg_write) begin
            r_n         <= w_n_cfg;
            r_sum       <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_max_age   <= '0;
            r_min_age   <= '0;
            r_prev      <= '0;
            r_bar       <= '0;
            r_wpos      <= '0;
            r_newest    <= '0;
            r_scan_max  <= 1'b0;
            r_scan_min  <= 1'b0;
            r_scan_done <= 1'b0;
        end else begin
            r_scan_done <= w_proc_last;
            if (i_cmd.calc_tr) r_prev <= r_cl;
            if (i_cmd.load) begin
                r_sum    <= r_sum - SW'(w_old) + SW'(r_tr);
                r_newest <= r_wpos;
                r_wpos   <= (NW'(r_wpos) == r_n - NW'(1)) ? '0 : r_wpos + AW'(1);
                if (r_bar < r_n) r_bar <= r_bar + NW'(1);
                if (r_bar == '0) begin
                    r_max     <= r_tr;
                    r_min     <= r_tr;
                    r_max_age <= '0;
                    r_min_age <= '0;
                end else begin
                    if (w_max_age_inc >= r_n) begin
                        r_scan_max <= 1'b1;
                        r_max_age  <= w_max_age_inc;
                    end else if (r_max <= r_tr) begin
                        r_max     <= r_tr;
                        r_max_age <= '0;
                    end else begin
                        r_max_age <= w_max_age_inc;
                    end
                    if (w_min_age_inc >= r_n) begin
                        r_scan_min <= 1'b1;
                        r_min_age  <= w_min_age_inc;
                    end else if (r_min >= r_tr) begin
                        r_min     <= r_tr;
                        r_min_age <= '0;
                    end else begin
                        r_min_age <= w_min_age_inc;
                    end
                end
            end
            if (w_proc_last) begin
                if (r_scan_max) begin
                    r_max     <= w_bmax_nx;
                    r_max_age <= w_bmax_age_nx;
                end
                if (r_scan_min) begin
                    r_min     <= w_bmin_nx;
                    r_min_age <= w_bmin_age_nx;
                end
                r_scan_max <= 1'b0;
                r_scan_min <= 1'b0;
            end
        end
    end

    // window rescan, newest to oldest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_rd_v    <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_rd_v    <= r_issue;
            r_rd_last <= r_issue && (r_scan_age == r_n - NW'(1));
            r_rd_age  <= r_scan_age;
            if (i_cmd.scan_start) begin
                r_issue    <= 1'b1;
                r_scan_idx <= w_newest_prev;
                r_scan_age <= NW'(1);
            end else if (r_issue) begin
                r_scan_idx <= w_scan_prev;
                r_scan_age <= r_scan_age + NW'(1);
                if (r_scan_age == r_n - NW'(1)) r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_bmax     <= r_tr;
            r_bmin     <= r_tr;
            r_bmax_age <= '0;
            r_bmin_age <= '0;
        end else if (r_rd_v) begin
            r_bmax     <= w_bmax_nx;
            r_bmin     <= w_bmin_nx;
            r_bmax_age <= w_bmax_age_nx;
            r_bmin_age <= w_bmin_age_nx;
        end
    end

    always_comb begin
        case (i_cmd.log_sel)
            chop_pkg::LOG_SPREAD: w_log_x = XW'(r_max - r_min);
            chop_pkg::LOG_SUM:    w_log_x = XW'(r_sum);
            chop_pkg::LOG_LEN:    w_log_x = XW'(r_n);
            default:              w_log_x = XW'(r_n);
        endcase
    end

    chop_log #(
        .XW (XW)
    ) u_log (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.log_start),
        .i_x      (w_log_x),
        .o_done   (w_log_done),
        .o_result (w_log_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.log_start) r_log_sel <= i_cmd.log_sel;
        if (w_log_done) begin
            case (r_log_sel)
                chop_pkg::LOG_SPREAD: r_ld <= w_log_res;
                chop_pkg::LOG_SUM:    r_ls <= w_log_res;
                chop_pkg::LOG_LEN:    r_ln <= w_log_res;
                default:              r_ln <= w_log_res;
            endcase
        end
    end

    assign w_diff  = r_ls - r_ld;
    assign w_trial = {r_rem, r_dvd[DW-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_ln});

    // restoring divide, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run  <= 1'b0;
            r_div_done <= 1'b0;
        end else begin
            r_div_done <= 1'b0;
            if (i_cmd.mul) r_prod <= PW'(w_diff) * PW'(chop_pkg::SCALE_Q8);
            if (i_cmd.div_start) begin
                r_dvd     <= DW'(r_prod) + DW'(r_ln >> 1);
                r_rem     <= '0;
                r_cnt     <= CW'(DW);
                r_div_run <= 1'b1;
            end else if (r_div_run) begin
                r_rem <= w_qbit ? LW'(w_trial - {1'b0, r_ln}) : LW'(w_trial);
                r_dvd <= {r_dvd[DW-2:0], w_qbit};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_div_run  <= 1'b0;
                    r_div_done <= 1'b1;
                end
            end
        end
    end

    assign w_mag = (r_dvd > DW'(chop_pkg::OUT_MIN_MAG)) ? OW'(chop_pkg::OUT_MIN_MAG)
                                                          : r_dvd[OW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_undef) begin
            r_res   <= OW'(chop_pkg::OUT_MIN_MAG);
            r_undef <= 1'b1;
        end else if (i_cmd.set_zero) begin
            r_res   <= '0;
            r_undef <= 1'b0;
        end else if (i_cmd.set_div) begin
            r_res   <= OW'(0) - w_mag;
            r_undef <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index <= r_res;
            r_out_undef <= r_undef;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_index_value     = r_out_index;
    assign o_ratio_undefined = r_out_undef;

    assign o_status.scan_pend     = r_scan_max || r_scan_min;
    assign o_status.scan_done     = r_scan_done;
    assign o_status.emit          = (r_bar == r_n);
    assign o_status.undef         = (r_max == r_min) || (r_sum == '0);
    assign o_status.log_done      = w_log_done;
    assign o_status.spread_ge_sum = (r_ld >= r_ls);
    assign o_status.div_done      = r_div_done;
    assign o_status.out_free      = !r_out_valid || i_out_ready;

    `CHOP_ASSERT_IMPL(a_extreme_order, i_clk, i_rst_n, 1'b1, r_max >= r_min)
    `CHOP_ASSERT_IMPL(a_wpos_range, i_clk, i_rst_n, 1'b1, NW'(r_wpos) < r_n)
    `CHOP_ASSERT_IMPL(a_count_cap, i_clk, i_rst_n, 1'b1, r_bar <= r_n)

endmodule

// ----- rtl/chop_ctrl.sv -----
`include "choppiness_index_of_true_range_defines.svh"

module chop_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    output chop_pkg::t_cmd    o_cmd,
    input  chop_pkg::t_status i_status
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_TR    = 13'b0000000000010,
        S_LOAD  = 13'b0000000000100,
        S_CHECK = 13'b0000000001000,
        S_SCAN  = 13'b0000000010000,
        S_LOGD  = 13'b0000000100000,
        S_LOGS  = 13'b0000001000000,
        S_CMP   = 13'b0000010000000,
        S_LOGN  = 13'b0000100000000,
        S_MUL   = 13'b0001000000000,
        S_DIVS  = 13'b0010000000000,
        S_DIV   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cfg_ready     = 1'b1;
                o_in_ready      = !i_cfg_valid;
                o_cmd.cfg_write = i_cfg_valid;
                if (i_in_valid && !i_cfg_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_TR;
                end
            end
            S_TR: begin
                o_cmd.calc_tr = 1'b1;
                n_state       = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.scan_pend) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (!i_status.emit) begin
                    n_state = S_IDLE;
                end else if (i_status.undef) begin
                    o_cmd.set_undef = 1'b1;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.log_start = 1'b1;
                    o_cmd.log_sel   = chop_pkg::LOG_SPREAD;
                    n_state         = S_LOGD;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) n_state = S_CHECK;
            end
            S_LOGD: begin
                if (i_status.log_done) begin
                    o_cmd.log_start = 1'b1;
                    o_cmd.log_sel   = chop_pkg::LOG_SUM;
                    n_state         = S_LOGS;
                end
            end
            S_LOGS: begin
                if (i_status.log_done) n_state = S_CMP;
            end
            S_CMP: begin
                if (i_status.spread_ge_sum) begin
                    o_cmd.set_zero = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.log_start = 1'b1;
                    o_cmd.log_sel   = chop_pkg::LOG_LEN;
                    n_state         = S_LOGN;
                end
            end
            S_LOGN: begin
                if (i_status.log_done) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.set_div = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `CHOP_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `CHOP_ASSERT_IMPL(a_log_in_state, i_clk, i_rst_n, i_status.log_done, r_state == S_LOGD || r_state == S_LOGS || r_state == S_LOGN)
    `CHOP_ASSERT_IMPL(a_div_in_state, i_clk, i_rst_n, i_status.div_done, r_state == S_DIV)

endmodule

// ----- rtl/choppiness_index_of_true_range.sv -----
// a bar is captured, its true range computed and loaded into the window; an extreme that
// ages out triggers a rescan; a nonzero result adds three passes of the serial log unit
// and a restoring divide, a zero result two log passes, an undefined result neither
// throughput: one bar at a time, set by the log unit and the divider
// reset: synchronous, clears the running window state and sets period_len to 14
// a period_len write clears the same state; the range memory is not cleared
module choppiness_index_of_true_range #(
    parameter int WINDOW_MAX = chop_pkg::WINDOW_MAX_DEF,
    parameter int PRICE_BITS = chop_pkg::PRICE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [chop_pkg::PORT_PRICE_W-1:0]   i_high_price,
    input  logic [chop_pkg::PORT_PRICE_W-1:0]   i_low_price,
    input  logic [chop_pkg::PORT_PRICE_W-1:0]   i_close_price,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [chop_pkg::OUT_W-1:0]   o_index_value,
    output logic                                o_ratio_undefined,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [chop_pkg::PERIOD_W-1:0]       i_cfg_period_len
);

    chop_pkg::t_cmd    w_cmd;
    chop_pkg::t_status w_status;

    chop_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    chop_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_high_price      (i_high_price),
        .i_low_price       (i_low_price),
        .i_close_price     (i_close_price),
        .i_cfg_period_len  (i_cfg_period_len),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_index_value     (o_index_value),
        .o_ratio_undefined (o_ratio_undefined)
    );

endmodule
